// File: rtl/sst_pkg.sv
// Package with shared types and defaults for the sorted set table.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

	localparam int SST_CAPACITY  = 16;
	localparam int SST_ELEM_BITS = 32;
	localparam int SST_WORD_BITS = 32;
	localparam int SST_CNT_BITS  = 5;
	localparam int SST_RANK_BITS = 8;

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_DELETE = 3'd1,
		ACT_MEMBER = 3'd2,
		ACT_KTH    = 3'd3,
		ACT_KEEP   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_SHIFT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic [SST_RANK_BITS-1:0] rank;
	} sst_ctl_t;

	typedef struct packed {
		logic [2:0]               action;
		logic [SST_WORD_BITS-1:0] value;
		logic [SST_WORD_BITS-1:0] range_end;
		logic [SST_RANK_BITS-1:0] position;
	} sst_req_t;

	typedef struct packed {
		logic                     found;
		logic [SST_WORD_BITS-1:0] element;
		logic [SST_CNT_BITS-1:0]  count;
		logic                     full_reject;
	} sst_rsp_t;

endpackage

`default_nettype wire

// File: rtl/sst_cell.sv
// One table slot: holds an entry, compares it with the key and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sst_cell
	import sst_pkg::*;
#(
	parameter int ELEM_BITS = SST_ELEM_BITS,
	parameter int CNT_BITS  = SST_CNT_BITS,
	parameter int IDX       = 0
) (
	input  wire logic                 clk,
	input  wire sst_ctl_t             ctl,
	input  wire logic [CNT_BITS-1:0]  count,
	input  wire logic [ELEM_BITS-1:0] key,
	input  wire logic [ELEM_BITS-1:0] bound,
	input  wire logic [ELEM_BITS-1:0] left_q,
	input  wire logic                 left_lt,
	input  wire logic [ELEM_BITS-1:0] right_q,
	output logic      [ELEM_BITS-1:0] q,
	output logic                      lt,
	output logic                      eq,
	output logic                      le,
	output logic                      kth_hit
);

	localparam logic [CNT_BITS-1:0]      SLOT = CNT_BITS'(IDX);
	localparam logic [SST_RANK_BITS:0]   RANK = (SST_RANK_BITS + 1)'(IDX + 1);

	logic [ELEM_BITS-1:0] entry_q;
	logic                 valid;

	assign valid   = SLOT < count;
	assign q       = entry_q;
	assign lt      = valid && (entry_q < key);
	assign eq      = valid && (entry_q == key);
	assign le      = valid && (entry_q <= bound);
	assign kth_hit = valid && ({1'b0, ctl.rank} == RANK);

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (!lt) begin
					entry_q <= left_lt ? key : left_q;
				end
			end
			CELL_DELETE: begin
				if (!lt) begin
					entry_q <= right_q;
				end
			end
			CELL_SHIFT: begin
				entry_q <= right_q;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/sorted_set_table.sv
// Top level of the sorted set table: request decode, cell chain and result register.
//
// The block keeps a set of distinct values in ascending order in a row of CAPACITY cells.
// Requests arrive on req (req_valid/req_ready), one word per request; each request gives
// exactly one result word on rsp (rsp_valid/rsp_ready).
// Insert, delete, member test and get-kth finish in the cycle they are accepted; the
// result is registered and shows on rsp in the next cycle, and a new request can be taken
// every cycle as long as the result register drains.
// A keep-range whose start is above its end empties the set and finishes the same way.
// Otherwise keep-range drops the entries below the range start one per cycle by shifting
// the whole chain toward cell zero, then trims the top; no request is taken meanwhile.
// The result register holds its word while rsp_ready is low; a new request is taken only
// when that register is empty or being emptied in the same cycle.
// After reset the set is empty and results may be requested at once; the cell contents
// are not cleared, since slots above the count are never looked at.
// The count field reports the element count in five bits.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_table
	import sst_pkg::*;
#(
	parameter int CAPACITY  = SST_CAPACITY,
	parameter int ELEM_BITS = SST_ELEM_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire sst_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output sst_rsp_t      rsp
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(CAPACITY);

	typedef enum logic {
		ST_IDLE,
		ST_TRIM
	} state_t;

	state_t               state_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [ELEM_BITS-1:0] key_q;
	logic [ELEM_BITS-1:0] bound_q;
	logic                 rsp_valid_q;
	sst_rsp_t             rsp_q;

	logic [ELEM_BITS-1:0] req_key;
	logic [ELEM_BITS-1:0] req_bound;
	logic [ELEM_BITS-1:0] key;
	logic [ELEM_BITS-1:0] bound;
	logic                 accept;
	sst_ctl_t             ctl;

	logic [ELEM_BITS-1:0] q_w [CAPACITY];
	logic [CAPACITY-1:0]  lt_w;
	logic [CAPACITY-1:0]  eq_w;
	logic [CAPACITY-1:0]  le_w;
	logic [CAPACITY-1:0]  kth_w;

	logic                 hit;
	logic [ELEM_BITS-1:0] kth_q;
	logic [CNT_BITS-1:0]  le_cnt;
	logic [63:0]          kth_wide;

	logic                 st_next_trim;
	logic                 st_done;
	logic                 rsp_load;
	logic                 rsp_found;
	logic                 rsp_reject;
	logic                 rsp_kth;
	logic [CNT_BITS-1:0]  count_next;
	logic [15:0]          count_wide;

	assign req_key   = ELEM_BITS'(64'(req.value));
	assign req_bound = ELEM_BITS'(64'(req.range_end));
	assign key       = (state_q == ST_TRIM) ? key_q : req_key;
	assign bound     = (state_q == ST_TRIM) ? bound_q : req_bound;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_BITS-1:0] left_q;
		logic                 left_lt;
		logic [ELEM_BITS-1:0] right_q;

		if (i == 0) begin : g_first
			assign left_q  = '0;
			assign left_lt = 1'b1;
		end else begin : g_mid
			assign left_q  = q_w[i-1];
			assign left_lt = lt_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_q = q_w[i];
		end else begin : g_inner
			assign right_q = q_w[i+1];
		end

		sst_cell #(
			.ELEM_BITS (ELEM_BITS),
			.CNT_BITS  (CNT_BITS),
			.IDX       (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.count   (count_q),
			.key     (key),
			.bound   (bound),
			.left_q  (left_q),
			.left_lt (left_lt),
			.right_q (right_q),
			.q       (q_w[i]),
			.lt      (lt_w[i]),
			.eq      (eq_w[i]),
			.le      (le_w[i]),
			.kth_hit (kth_w[i])
		);
	end

	always_comb begin
		hit    = |eq_w;
		kth_q  = '0;
		le_cnt = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (kth_w[i]) begin
				kth_q = kth_q | q_w[i];
			end
			if (le_w[i] && ((i == CAPACITY - 1) || !le_w[(i + 1) % CAPACITY])) begin
				le_cnt = le_cnt | CNT_BITS'(i + 1);
			end
		end
	end

	assign kth_wide = 64'(kth_q);

	always_comb begin
		ctl.op       = CELL_HOLD;
		ctl.rank     = req.position;
		st_next_trim = 1'b0;
		st_done      = 1'b0;
		rsp_load     = 1'b0;
		rsp_found    = 1'b0;
		rsp_reject   = 1'b0;
		rsp_kth      = 1'b0;
		count_next   = count_q;
		if (state_q == ST_TRIM) begin
			if (lt_w[0]) begin
				ctl.op     = CELL_SHIFT;
				count_next = count_q - 1'b1;
			end else begin
				count_next = le_cnt;
				rsp_load   = 1'b1;
				st_done    = 1'b1;
			end
		end else if (accept) begin
			rsp_load = 1'b1;
			case (req.action)
				ACT_INSERT: begin
					if (hit) begin
						rsp_found = 1'b1;
					end else if (count_q == CNT_FULL) begin
						rsp_reject = 1'b1;
					end else begin
						ctl.op     = CELL_INSERT;
						count_next = count_q + 1'b1;
					end
				end
				ACT_DELETE: begin
					if (hit) begin
						ctl.op     = CELL_DELETE;
						count_next = count_q - 1'b1;
						rsp_found  = 1'b1;
					end
				end
				ACT_MEMBER: begin
					rsp_found = hit;
				end
				ACT_KTH: begin
					rsp_found = |kth_w;
					rsp_kth   = 1'b1;
				end
				ACT_KEEP: begin
					if (req_key > req_bound) begin
						count_next = '0;
					end else begin
						rsp_load     = 1'b0;
						st_next_trim = 1'b1;
					end
				end
				default: begin
					rsp_found = 1'b0;
				end
			endcase
		end
		count_wide = 16'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (st_next_trim) begin
				state_q <= ST_TRIM;
			end else if (st_done) begin
				state_q <= ST_IDLE;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_next_trim) begin
			key_q   <= req_key;
			bound_q <= req_bound;
		end
		if (rsp_load) begin
			rsp_q.found       <= rsp_found;
			rsp_q.element     <= rsp_kth ? kth_wide[SST_WORD_BITS-1:0] : '0;
			rsp_q.count       <= count_wide[SST_CNT_BITS-1:0];
			rsp_q.full_reject <= rsp_reject;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("element count above capacity");

	a_trim_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRIM |-> !req_ready)
		else $error("request taken during range trim");

	a_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_w))
		else $error("duplicate value stored in table");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && rsp_reject |-> count_q == CNT_FULL && ctl.op == CELL_HOLD)
		else $error("insert refused while table not full");

endmodule

`default_nettype wire
